// ----- src/mps_pkg.sv -----
package mps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_KERNEL = 7;

  localparam int LINE_BANKS = MAX_KERNEL - 1;
  localparam int BANK_W     = (LINE_BANKS > 1) ? $clog2(LINE_BANKS) : 1;

  localparam int PIX_W      = 8;
  localparam int POOL_W     = 7;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * MAX_KERNEL + 1);
  localparam int K_W    = $clog2(MAX_KERNEL + 1);

  localparam int LAG_L_MAX = MAX_KERNEL - 1 - MAX_KERNEL / 2;
  localparam int LAG_MAX   = LAG_L_MAX * MAX_WIDTH + LAG_L_MAX;
  localparam int LAG_W     = (LAG_MAX > 0) ? $clog2(LAG_MAX + 1) : 1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_PLANE_HEIGHT = 2'd1,
    CFG_PLANE_WIDTH  = 2'd2,
    CFG_PLANE_COUNT  = 2'd3
  } mps_cfg_idx_t;

  typedef struct packed {
    logic                    func;
    logic signed [PIX_W-1:0] sample;
  } mps_in_t;

  typedef struct packed {
    logic [POOL_W-1:0] pooled_value;
    logic              end_of_plane;
    logic              end_of_tensor;
  } mps_out_t;

  typedef struct packed {
    logic                  write;
    logic                  emit;
    logic                  eop;
    logic                  eot;
    logic [BANK_W-1:0]     bank;
    logic [COL_W-1:0]      col;
    logic [MAX_KERNEL-1:0] vmask;
    logic [MAX_KERNEL-1:0] hmask;
    logic [PIX_W-1:0]      pixel;
  } mps_step_t;

endpackage

// ----- src/mps_ram.sv -----
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a shared address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mps_window.sv -----
module mps_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                flush,
  input  logic                step_valid,
  input  mps_pkg::mps_step_t  step,
  output logic                step_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mps_pkg::mps_out_t   out_data
);

  import mps_pkg::*;

  logic [PIX_W-1:0]      bank_q [LINE_BANKS];

  logic                  s1_valid;
  mps_step_t             s1;
  logic                  s2_valid;
  logic                  s2_eop;
  logic                  s2_eot;
  logic [MAX_KERNEL-1:0] s2_hmask;
  logic [POOL_W-1:0]     hreg [MAX_KERNEL];

  logic [POOL_W-1:0]     colmax;
  logic [POOL_W-1:0]     pool;
  logic                  out_free;
  logic                  s2_go;
  logic                  s1_go;
  logic                  s1_move;

  function automatic logic [POOL_W-1:0] relu(input logic [PIX_W-1:0] v);
    return v[PIX_W-1] ? '0 : v[POOL_W-1:0];
  endfunction

  for (genvar b = 0; b < LINE_BANKS; b++) begin : g_bank
    mps_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .we      (step_valid && step.write && (step.bank == BANK_W'(b))),
      .wr_addr (step.col),
      .wr_data (step.pixel),
      .re      (step_valid),
      .rd_addr (step.col),
      .rd_data (bank_q[b])
    );
  end

  assign out_free   = !out_valid || out_ready;
  assign s2_go      = !s2_valid || out_free;
  assign s1_go      = !s1_valid || s2_go;
  assign s1_move    = s1_valid && s2_go;
  assign step_ready = s1_go;

  // vertical max over the rows held in the line banks plus the new pixel
  always_comb begin
    logic [BANK_W:0]   idx;
    logic [POOL_W-1:0] v;
    colmax = s1.vmask[0] ? relu(s1.pixel) : '0;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      idx = {1'b0, s1.bank} + (BANK_W+1)'(LINE_BANKS - d);
      if (idx >= (BANK_W+1)'(LINE_BANKS)) begin
        idx = idx - (BANK_W+1)'(LINE_BANKS);
      end
      v = relu(bank_q[idx[BANK_W-1:0]]);
      if (s1.vmask[d] && (v > colmax)) begin
        colmax = v;
      end
    end
  end

  // horizontal max over the column history
  always_comb begin
    pool = '0;
    for (int s = 0; s < MAX_KERNEL; s++) begin
      if (s2_hmask[s] && (hreg[s] > pool)) begin
        pool = hreg[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid <= step_valid;
      end
      if (s2_go) begin
        s2_valid <= s1_valid && s1.emit;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_valid) begin
      s1 <= step;
    end
    if (s1_move) begin
      hreg[0] <= colmax;
      for (int s = 1; s < MAX_KERNEL; s++) begin
        hreg[s] <= hreg[s-1];
      end
      s2_hmask <= s1.hmask;
      s2_eop   <= s1.eop;
      s2_eot   <= s1.eot;
    end
    if (out_free && s2_valid) begin
      out_data.pooled_value  <= pool;
      out_data.end_of_plane  <= s2_eop;
      out_data.end_of_tensor <= s2_eot;
    end
  end

`ifndef SYNTHESIS
  a_step_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> step_ready)
    else $error("step issued while first stage busy");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    !flush && s1_valid && !s2_go |=> s1_valid && $stable(s1))
    else $error("first stage lost its item under stall");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    !flush && s2_valid && !out_free |=> s2_valid && $stable(hreg[0]) && $stable(s2_hmask))
    else $error("column history moved under stall");
`endif

endmodule

// ----- src/max_pool_same_padding_stream_top.sv -----
// Streaming max pooling (window side K = 1..7, stride 1, same padding) over planes
// of signed 8-bit pixels in raster order; each result is the window maximum floored at zero.
// One beat is taken per clock while in_ready is high; back-pressure on out_ready stalls it. A
// result passes the registered line bank read, column max and row max stages. Results trail
// the pixels by L rows and L columns, L = K-1-K/2; once a plane is in, drain beats (func = 1)
// push out the remaining results, one each. When a plane holds fewer than L*(W+1) pixels,
// in_ready drops after its last pixel while the window history fills. The line store is six
// line banks of 256 pixels, one read per bank per cycle; it needs no clearing after reset. Any
// register write restarts the stream and drops pending results; in_ready is low during a write.
module max_pool_same_padding_stream_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mps_pkg::mps_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mps_pkg::mps_out_t                   out_data
);

  import mps_pkg::*;

  logic [K_W-1:0]    k_eff;
  logic [HDIM_W-1:0] h_eff;
  logic [WDIM_W-1:0] w_eff;
  logic [CNT_W-1:0]  cnt_eff;

  logic [ROW_W-1:0]  seq_row;
  logic [COL_W-1:0]  seq_col;
  logic [OROW_W-1:0] out_row;
  logic [COL_W-1:0]  out_col;
  logic [LAG_W-1:0]  pre_cnt;
  logic [BANK_W-1:0] bank;
  logic [CNT_W-1:0]  plane_index;

  logic [K_W-1:0]    l_eff;
  logic [LAG_W-1:0]  lag;
  logic              complete;
  logic              fill_need;
  logic              step_ready;
  logic              accept;
  logic              pix_step;
  logic              drn_step;
  logic              fill_step;
  logic              do_step;
  logic              emit;
  logic              last;
  logic              tensor_end;
  logic              cfg_hit;
  logic [WDIM_W-1:0] col_inc;
  logic              col_wrap;
  logic [WDIM_W-1:0] ocol_inc;
  logic              ocol_wrap;
  logic [WDIM_W:0]   hpos;
  mps_step_t         step;

  function automatic logic [K_W-1:0] eff_k(input logic [2:0] v);
    if (v == 3'd0) begin
      return K_W'(1);
    end else if (32'(v) > MAX_KERNEL) begin
      return K_W'(MAX_KERNEL);
    end
    return K_W'(v);
  endfunction

  function automatic logic [HDIM_W-1:0] eff_h(input logic [8:0] v);
    if (v == 9'd0) begin
      return HDIM_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HDIM_W'(MAX_HEIGHT);
    end
    return HDIM_W'(v);
  endfunction

  function automatic logic [WDIM_W-1:0] eff_w(input logic [8:0] v);
    if (v == 9'd0) begin
      return WDIM_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WDIM_W'(MAX_WIDTH);
    end
    return WDIM_W'(v);
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      CFG_KERNEL_SIZE:  cfg_hit = 1'b1;
      CFG_PLANE_HEIGHT: cfg_hit = 1'b1;
      CFG_PLANE_WIDTH:  cfg_hit = 1'b1;
      CFG_PLANE_COUNT:  cfg_hit = 1'b1;
      default:          cfg_hit = 1'b0;
    endcase
  end

  assign l_eff = k_eff - K_W'(1) - (k_eff >> 1);
  assign lag   = LAG_W'(l_eff) * LAG_W'(w_eff) + LAG_W'(l_eff);

  assign complete  = seq_row >= ROW_W'(h_eff);
  assign fill_need = complete && (pre_cnt < lag);

  assign in_ready  = step_ready && !fill_need && !cfg_valid;
  assign accept    = in_valid && in_ready;
  assign pix_step  = accept && (in_data.func == FUNC_PIXEL) && !complete;
  assign drn_step  = accept && (in_data.func == FUNC_DRAIN) && complete;
  assign fill_step = step_ready && fill_need;
  assign do_step   = !cfg_valid && (pix_step || drn_step || fill_step);
  assign emit      = !cfg_valid && ((pix_step && (pre_cnt >= lag)) || drn_step);

  assign last       = (HDIM_W'(out_row) == h_eff - HDIM_W'(1))
                   && (WDIM_W'(out_col) == w_eff - WDIM_W'(1));
  assign tensor_end = last && (plane_index >= cnt_eff - CNT_W'(1));

  assign col_inc   = WDIM_W'(seq_col) + WDIM_W'(1);
  assign col_wrap  = col_inc >= w_eff;
  assign ocol_inc  = WDIM_W'(out_col) + WDIM_W'(1);
  assign ocol_wrap = ocol_inc >= w_eff;
  assign hpos      = (WDIM_W+1)'(out_col) + (WDIM_W+1)'(l_eff);

  always_comb begin
    step.write = pix_step;
    step.emit  = emit;
    step.eop   = emit && last;
    step.eot   = emit && tensor_end;
    step.bank  = bank;
    step.col   = seq_col;
    step.pixel = in_data.sample;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      step.vmask[d] = (K_W'(d) < k_eff) && (seq_row >= ROW_W'(d))
                   && ({1'b0, seq_row} < ((ROW_W+1)'(h_eff) + (ROW_W+1)'(d)));
      step.hmask[d] = (K_W'(d) < k_eff) && ((WDIM_W+1)'(d) <= hpos)
                   && (hpos < ((WDIM_W+1)'(w_eff) + (WDIM_W+1)'(d)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff       <= K_W'(3);
      h_eff       <= HDIM_W'(32);
      w_eff       <= WDIM_W'(32);
      cnt_eff     <= CNT_W'(1);
      seq_row     <= '0;
      seq_col     <= '0;
      out_row     <= '0;
      out_col     <= '0;
      pre_cnt     <= '0;
      bank        <= '0;
      plane_index <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KERNEL_SIZE:  k_eff   <= eff_k(cfg_data[2:0]);
        CFG_PLANE_HEIGHT: h_eff   <= eff_h(cfg_data[8:0]);
        CFG_PLANE_WIDTH:  w_eff   <= eff_w(cfg_data[8:0]);
        CFG_PLANE_COUNT:  cnt_eff <= (cfg_data == '0) ? CNT_W'(1) : cfg_data;
        default: ;
      endcase
      if (cfg_hit) begin
        seq_row     <= '0;
        seq_col     <= '0;
        out_row     <= '0;
        out_col     <= '0;
        pre_cnt     <= '0;
        bank        <= '0;
        plane_index <= '0;
      end
    end else if (do_step) begin
      if (emit && last) begin
        seq_row <= '0;
        seq_col <= '0;
        out_row <= '0;
        out_col <= '0;
        pre_cnt <= '0;
        bank    <= '0;
        if (tensor_end) begin
          plane_index <= '0;
        end else begin
          plane_index <= plane_index + CNT_W'(1);
        end
      end else begin
        if (col_wrap) begin
          seq_col <= '0;
          seq_row <= seq_row + ROW_W'(1);
          bank    <= (bank == BANK_W'(LINE_BANKS - 1)) ? '0 : bank + BANK_W'(1);
        end else begin
          seq_col <= seq_col + COL_W'(1);
        end
        if (pre_cnt < lag) begin
          pre_cnt <= pre_cnt + LAG_W'(1);
        end
        if (emit) begin
          if (ocol_wrap) begin
            out_col <= '0;
            out_row <= out_row + OROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  mps_window u_window (
    .clk        (clk),
    .rst        (rst),
    .flush      (cfg_valid),
    .step_valid (do_step),
    .step       (step),
    .step_ready (step_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    plane_index < cnt_eff)
    else $error("plane index beyond plane count");

  a_tensor_end_is_plane_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_tensor |-> out_data.end_of_plane)
    else $error("tensor end without plane end");

  a_complete_sticks: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid && complete && !(emit && last) |=> complete)
    else $error("plane input reopened before its last result");
`endif

endmodule
